@@ sv/drm_pkg.sv @@
// ============================================================================
// drm_pkg
// Shared types and constants for the dirty row range merger.
// ============================================================================
package drm_pkg;

    localparam int MAX_RANGES = 16;
    localparam int ROW_BITS   = 12;

    localparam int CMD_W  = 2;
    localparam int ROW_W  = ROW_BITS;
    localparam int CNT_W  = ROW_BITS + 1;
    localparam int POS_W  = ROW_BITS + 1;
    localparam int SUM_W  = POS_W + 1;
    localparam int OCC_W  = $clog2(MAX_RANGES + 1);
    localparam int STAT_W = 2;

    localparam logic [POS_W-1:0] END_LIMIT = {POS_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_MARK  = 2'd0,
        CMD_FLUSH = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef struct packed {
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } t_range;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic pop;
        logic push;
        logic done;
        logic overflow;
    } t_mark_step;

    typedef enum logic [1:0] {
        M_BEFORE  = 2'd0,
        M_MERGING = 2'd1,
        M_AFTER   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_MARK  = 2'd1,
        S_REPLY = 2'd2,
        S_FLUSH = 2'd3
    } t_state;

endpackage

@@ sv/drm_cell.sv @@
// ============================================================================
// drm_cell
// One slot of the range chain: holds one range and shifts toward the head.
// ============================================================================
module drm_cell (
    input  logic               i_clk,
    input  drm_pkg::t_cell_ctl i_ctl,
    input  drm_pkg::t_range    i_right,
    input  drm_pkg::t_range    i_push,
    output drm_pkg::t_range    o_range
);
    import drm_pkg::*;

    t_range r_range;
    t_range n_range;

    // A load from the merge engine wins over the shift from the neighbor.
    always_comb begin
        n_range = r_range;
        if (i_ctl.load) begin
            n_range = i_push;
        end else if (i_ctl.shift) begin
            n_range = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_range <= n_range;
    end

    assign o_range = r_range;

endmodule

@@ sv/drm_mark_unit.sv @@
// ============================================================================
// drm_mark_unit
// Merge engine: streams the stored ranges from the chain head and writes the
// updated list back at the tail, one range per cycle unless a new or merged range goes ahead of the head.
// ============================================================================
module drm_mark_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [drm_pkg::POS_W-1:0]  i_first,
    input  logic [drm_pkg::POS_W-1:0]  i_end,
    input  logic [drm_pkg::OCC_W-1:0]  i_count,
    input  drm_pkg::t_range            i_head,
    output drm_pkg::t_mark_step        o_step,
    output drm_pkg::t_range            o_push_data
);
    import drm_pkg::*;

    logic             r_busy, n_busy;
    t_mode            r_mode, n_mode;
    logic [OCC_W-1:0] r_rem,  n_rem;
    t_range           r_cur,  n_cur;
    logic [POS_W-1:0] r_first, n_first;
    logic [POS_W-1:0] r_end,   n_end;
    logic             r_full,  n_full;
    logic             r_ovf,   n_ovf;

    t_mark_step w_step;
    t_range     w_push;
    logic       w_ovf_now;

    always_comb begin
        n_busy    = r_busy;
        n_mode    = r_mode;
        n_rem     = r_rem;
        n_cur     = r_cur;
        n_first   = r_first;
        n_end     = r_end;
        n_full    = r_full;
        n_ovf     = r_ovf;
        w_step    = '0;
        w_push    = i_head;
        w_ovf_now = 1'b0;

        if (i_start) begin
            n_busy  = 1'b1;
            n_mode  = M_BEFORE;
            n_rem   = i_count;
            n_first = i_first;
            n_end   = i_end;
            n_full  = (i_count == OCC_W'(MAX_RANGES));
            n_ovf   = 1'b0;
        end else if (r_busy) begin
            if (r_rem != '0) begin
                case (r_mode)
                    M_BEFORE: begin
                        if (i_head.hi < r_first) begin
                            // Range lies wholly below the new one: copy it.
                            w_step.pop  = 1'b1;
                            w_step.push = 1'b1;
                            if (r_full && (r_rem == OCC_W'(1))) begin
                                // Full table, nothing follows: stretch the last range.
                                w_push.hi      = r_end;
                                w_ovf_now      = 1'b1;
                                w_step.done    = 1'b1;
                                n_busy         = 1'b0;
                            end
                        end else if (r_end < i_head.lo) begin
                            w_step.push = 1'b1;
                            n_mode      = M_AFTER;
                            if (r_full) begin
                                // Full table: the following range absorbs the new one.
                                w_step.pop = 1'b1;
                                w_push.lo  = r_first;
                                w_ovf_now  = 1'b1;
                            end else begin
                                // Insert ahead of the head, which stays for next cycle.
                                w_push = '{lo: r_first, hi: r_end};
                            end
                        end else begin
                            w_step.pop = 1'b1;
                            n_cur.lo   = (i_head.lo < r_first) ? i_head.lo : r_first;
                            n_cur.hi   = (i_head.hi > r_end)   ? i_head.hi : r_end;
                            n_mode     = M_MERGING;
                        end
                    end
                    M_MERGING: begin
                        if (r_cur.hi >= i_head.lo) begin
                            w_step.pop = 1'b1;
                            if (i_head.hi > r_cur.hi) begin
                                n_cur.hi = i_head.hi;
                            end
                        end else begin
                            w_step.push = 1'b1;
                            w_push      = r_cur;
                            n_mode      = M_AFTER;
                        end
                    end
                    M_AFTER: begin
                        w_step.pop  = 1'b1;
                        w_step.push = 1'b1;
                    end
                    default: begin
                        n_mode = M_AFTER;
                    end
                endcase
            end else begin
                // Every stored range has passed; close out the pass.
                case (r_mode)
                    M_BEFORE: begin
                        w_step.push = 1'b1;
                        w_push      = '{lo: r_first, hi: r_end};
                    end
                    M_MERGING: begin
                        w_step.push = 1'b1;
                        w_push      = r_cur;
                    end
                    default: begin
                    end
                endcase
                w_step.done = 1'b1;
                n_busy      = 1'b0;
            end

            if (w_step.pop) begin
                n_rem = r_rem - OCC_W'(1);
            end
            n_ovf = r_ovf | w_ovf_now;
        end

        w_step.overflow = r_ovf | w_ovf_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mode <= M_BEFORE;
            r_rem  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_mode <= n_mode;
            r_rem  <= n_rem;
            r_ovf  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_first <= n_first;
        r_end   <= n_end;
        r_full  <= n_full;
    end

    assign o_step      = w_step;
    assign o_push_data = w_push;

endmodule

@@ sv/dirty_row_range_merger_core.sv @@
// ============================================================================
// dirty_row_range_merger_core
// Sorted set of disjoint row ranges with merging mark, flush and clear.
// ============================================================================
// Usage: each input beat carries a command with first_row and row_count.
// A mark inserts [first_row, first_row + row_count) into the set, merging it
// with every stored range that overlaps or touches it, and answers one beat
// with last set and status ok, or overflow when the table was full and the
// new range had to be folded into a neighbor. A flush emits the stored
// ranges in ascending order, one beat each with status range emitted and
// last on the final one, then leaves the set empty; an empty set answers
// one beat with status flush found nothing. A clear empties the set and
// answers nothing; an unknown command is dropped.
// The ranges live in a chain of cells that shifts toward the head; a mark
// streams the chain through the merge engine before its answer is ready,
// and the next beat is taken once that answer sits in the output register.
// A flush sends one beat per cycle while the receiver takes them.
// The block handles one input beat at a time: ready is high only while no
// beat is in progress. When the receiver stalls, the output beat holds and
// the work waits for it. Reset empties the set and drops any pending beat.
module dirty_row_range_merger_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [drm_pkg::CMD_W-1:0]   i_command,
    input  logic [drm_pkg::ROW_W-1:0]   i_first_row,
    input  logic [drm_pkg::CNT_W-1:0]   i_row_count,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [drm_pkg::POS_W-1:0]   o_range_start,
    output logic [drm_pkg::POS_W-1:0]   o_range_end,
    output logic                        o_last,
    output logic [drm_pkg::STAT_W-1:0]  o_status
);
    import drm_pkg::*;

    t_state           r_state, n_state;
    logic [OCC_W-1:0] r_occ,   n_occ;
    t_status          r_reply, n_reply;

    logic             r_out_valid, n_out_valid;
    logic [POS_W-1:0] r_out_start, n_out_start;
    logic [POS_W-1:0] r_out_end,   n_out_end;
    logic             r_out_last,  n_out_last;
    t_status          r_out_status, n_out_status;

    // Chain wiring.
    t_range     w_cells [MAX_RANGES];
    t_cell_ctl  w_ctl   [MAX_RANGES];
    t_range     w_head;
    t_range     w_push_data;
    t_mark_step w_step;
    logic       w_pop;
    logic       w_flush_pop;
    logic [OCC_W-1:0] w_wr_idx;

    logic             w_accept;
    logic             w_start;
    logic             w_out_free;
    logic             w_out_load;
    logic [SUM_W-1:0] w_sum;
    logic [POS_W-1:0] w_first;
    logic [POS_W-1:0] w_end;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_head     = w_cells[0];

    // End row of the marked range, saturated at END_LIMIT, the largest POS_W-bit position.
    assign w_first = POS_W'(i_first_row);
    assign w_sum   = SUM_W'(i_first_row) + SUM_W'(i_row_count);
    assign w_end   = (w_sum > SUM_W'(END_LIMIT)) ? END_LIMIT : w_sum[POS_W-1:0];

    drm_mark_unit u_mark (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_first     (w_first),
        .i_end       (w_end),
        .i_count     (r_occ),
        .i_head      (w_head),
        .o_step      (w_step),
        .o_push_data (w_push_data)
    );

    // A pop shifts every cell one place toward the head; a push writes the
    // first free slot, which moves down by one when a pop happens alongside.
    assign w_pop    = w_step.pop || w_flush_pop;
    assign w_wr_idx = w_pop ? (r_occ - OCC_W'(1)) : r_occ;

    for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
        t_range w_right;

        if (k == MAX_RANGES - 1) begin : g_tail
            assign w_right = w_push_data;
        end else begin : g_mid
            assign w_right = w_cells[k+1];
        end

        assign w_ctl[k].shift = w_pop;
        assign w_ctl[k].load  = w_step.push && (w_wr_idx == OCC_W'(k));

        drm_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[k]),
            .i_right (w_right),
            .i_push  (w_push_data),
            .o_range (w_cells[k])
        );
    end

    // Control sequencer.
    always_comb begin
        n_state      = r_state;
        n_reply      = r_reply;
        w_start      = 1'b0;
        w_flush_pop  = 1'b0;
        w_out_load   = 1'b0;
        n_out_start  = '0;
        n_out_end    = '0;
        n_out_last   = 1'b1;
        n_out_status = r_reply;
        o_in_ready   = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        CMD_MARK: begin
                            if (i_row_count == '0) begin
                                n_reply = ST_OK;
                                n_state = S_REPLY;
                            end else begin
                                w_start = 1'b1;
                                n_state = S_MARK;
                            end
                        end
                        CMD_FLUSH: begin
                            if (r_occ == '0) begin
                                n_reply = ST_EMPTY;
                                n_state = S_REPLY;
                            end else begin
                                n_state = S_FLUSH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MARK: begin
                if (w_step.done) begin
                    n_reply = w_step.overflow ? ST_OVERFLOW : ST_OK;
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    w_flush_pop  = 1'b1;
                    n_out_start  = w_head.lo;
                    n_out_end    = w_head.hi;
                    n_out_last   = (r_occ == OCC_W'(1));
                    n_out_status = ST_RANGE;
                    if (r_occ == OCC_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Occupancy of the chain, which is the number of stored ranges at rest.
    always_comb begin
        n_occ = r_occ;
        if (w_accept && (i_command == CMD_CLEAR)) begin
            n_occ = '0;
        end else if (w_pop && !w_step.push) begin
            n_occ = r_occ - OCC_W'(1);
        end else if (w_step.push && !w_pop) begin
            n_occ = r_occ + OCC_W'(1);
        end
    end

    // Output register: a beat leaves on ready and a new one may load at once.
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_reply     <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_reply     <= n_reply;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_start  <= n_out_start;
            r_out_end    <= n_out_end;
            r_out_last   <= n_out_last;
            r_out_status <= n_out_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_range_start = r_out_start;
    assign o_range_end   = r_out_end;
    assign o_last        = r_out_last;
    assign o_status      = r_out_status;

endmodule

@@ sim/dirty_row_range_merger_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// dirty_row_range_merger_core_tb
// Self-checking bench for the dirty row range merger: mark, flush, clear and
// unknown beats go in, and every output beat is checked against an in-bench
// model of the sorted range table.
// ============================================================================
module dirty_row_range_merger_core_tb;
    import drm_pkg::*;

    // The command port is two bits wide and the fourth code has no meaning.
    // The block has to drop it without answering.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = MAX_RANGES + 24;
    localparam int LIMIT_CYCLES = 800000;
    localparam int RANDOM_ITEMS = 450;

    // One expected output beat.
    typedef struct {
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic             last;
        t_status          st;
    } t_range_beat;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the range table. Each accepted
    // input beat is applied to that copy, and the output beats the beat
    // should cause are queued. Each output beat is then checked against the
    // oldest entry in the queue.
    // ------------------------------------------------------------------------
    class t_range_scoreboard;
        logic [POS_W-1:0] lo_tab[MAX_RANGES];
        logic [POS_W-1:0] hi_tab[MAX_RANGES];
        int unsigned      held;
        t_range_beat      pending[$];
        int               errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        // Append one expected beat at the back of the queue.
        function void add_beat(t_range_beat beat);
            pending.insert(pending.size(), beat);
        endfunction

        // Add [s, e) to the table and merge it with every range that it
        // overlaps or touches. When the table is full and a separate entry
        // would be needed, the new range is folded into a neighbor instead.
        function t_status insert_rows(logic [POS_W-1:0] s, logic [POS_W-1:0] e);
            int unsigned i;
            int unsigned j;
            int unsigned k;
            int unsigned gone;
            if (e <= s)
                return ST_OK;
            i = 0;
            while (i < held && hi_tab[i] < s)
                i++;
            if (i == held) begin
                // Nothing ends at or after s, so the new range goes at the tail.
                if (held >= MAX_RANGES) begin
                    hi_tab[held-1] = e;
                    return ST_OVERFLOW;
                end
                lo_tab[held] = s;
                hi_tab[held] = e;
                held++;
                return ST_OK;
            end
            if (e < lo_tab[i]) begin
                // The new range sits strictly before entry i.
                if (held >= MAX_RANGES) begin
                    lo_tab[i] = s;
                    return ST_OVERFLOW;
                end
                for (k = held; k > i; k--) begin
                    lo_tab[k] = lo_tab[k-1];
                    hi_tab[k] = hi_tab[k-1];
                end
                lo_tab[i] = s;
                hi_tab[i] = e;
                held++;
                return ST_OK;
            end
            if (s < lo_tab[i])
                lo_tab[i] = s;
            if (e > hi_tab[i])
                hi_tab[i] = e;
            j = i + 1;
            while (j < held && hi_tab[i] >= lo_tab[j]) begin
                if (hi_tab[j] > hi_tab[i])
                    hi_tab[i] = hi_tab[j];
                j++;
            end
            if (j > i + 1) begin
                gone = j - (i + 1);
                for (k = j; k < held; k++) begin
                    lo_tab[k-gone] = lo_tab[k];
                    hi_tab[k-gone] = hi_tab[k];
                end
                held -= gone;
            end
            return ST_OK;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                                   logic [CNT_W-1:0] cnt);
            logic [SUM_W-1:0] stop;
            logic [POS_W-1:0] e;
            t_range_beat      beat;
            case (cmd)
                CMD_MARK: begin
                    stop = SUM_W'(row) + SUM_W'(cnt);
                    e    = (stop > SUM_W'(END_LIMIT)) ? END_LIMIT : stop[POS_W-1:0];
                    beat = '{lo: '0, hi: '0, last: 1'b1,
                             st: insert_rows(POS_W'(row), e)};
                    add_beat(beat);
                end
                CMD_FLUSH: begin
                    if (held == 0) begin
                        beat = '{lo: '0, hi: '0, last: 1'b1, st: ST_EMPTY};
                        add_beat(beat);
                    end else begin
                        for (int unsigned n = 0; n < held; n++) begin
                            beat = '{lo: lo_tab[n], hi: hi_tab[n],
                                     last: (n + 1 == held), st: ST_RANGE};
                            add_beat(beat);
                        end
                    end
                    held = 0;
                end
                CMD_CLEAR: held = 0;
                default: ;
            endcase
        endfunction

        function void check_result(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                                   logic last, logic [STAT_W-1:0] st);
            t_range_beat want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected range beat lo=%0d hi=%0d last=%0b status=%0d",
                                 lo, hi, last, st));
                return;
            end
            want = pending.pop_front();
            if (lo !== want.lo || hi !== want.hi || last !== want.last ||
                st !== want.st)
                report($sformatf({"range beat wrong: expected lo=%0d hi=%0d last=%0b ",
                                  "status=%0d, got lo=%0d hi=%0d last=%0b status=%0d"},
                                 want.lo, want.hi, want.last, want.st,
                                 lo, hi, last, st));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block inputs and the instance. Every input starts at a known
    // value, and the block is held in reset from time zero.
    // ------------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic [CMD_W-1:0]   i_command     = '0;
    logic [ROW_W-1:0]   i_first_row   = '0;
    logic [CNT_W-1:0]   i_row_count   = '0;
    logic               i_out_ready   = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [POS_W-1:0]   o_range_start;
    logic [POS_W-1:0]   o_range_end;
    logic               o_last;
    logic [STAT_W-1:0]  o_status;

    t_range_scoreboard  sb = new();

    // Sender and receiver pacing. Burst phases drop the random gaps on one
    // side. The long hold is started by the sender and timed by its own
    // process.
    bit                 tx_burst = 1'b0;
    bit                 rx_burst = 1'b0;
    bit                 hold_go  = 1'b0;
    logic               hold_rx  = 1'b0;
    int                 rx_wait  = 0;
    int unsigned        beats_seen = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    dirty_row_range_merger_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_first_row    (i_first_row),
        .i_row_count    (i_row_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_range_start  (o_range_start),
        .o_range_end    (o_range_end),
        .o_last         (o_last),
        .o_status       (o_status)
    );

    // ------------------------------------------------------------------------
    // Receiver. Signals are sampled right after the rising edge, so the
    // values seen are the ones the block saw at that edge. After each beat a
    // random gap is drawn, and ready stays low while rx_wait counts it down.
    // A zero gap keeps ready high, so beats can come back to back.
    // While the long hold is on, ready stays low whatever the gap.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_ready && o_out_valid) begin
                sb.check_result(o_range_start, o_range_end, o_last, o_status);
                beats_seen++;
                if (beats_seen % 64 == 0)
                    rx_burst = ($urandom_range(0, 3) == 0);
                rx_wait = rx_burst ? 0 : $urandom_range(0, 17);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_out_ready <= (rx_wait == 0) && !hold_rx;
        end
    end

    // Long stall on the output side. Once it is on, the block keeps one
    // result waiting, has no room for more work and drops its input ready.
    // The sender keeps offering beats the whole time.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // Hard limit on the run. It allows for every item causing a full flush
    // of sixteen beats, each beat waiting out the longest receiver gap.
    initial begin
        #(LIMIT_CYCLES * 8);
        $display("dirty_row_range_merger_core: mismatch");
        $finish;
    end

    // Offer one input beat and return at the edge where it is accepted.
    // Valid stays high with the payload unchanged until that edge. When the
    // next gap is zero, valid is not lowered, and the next call only changes
    // the payload.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                             input logic [CNT_W-1:0] cnt);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_first_row <= row;
        i_row_count <= cnt;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_command(cmd, row, cnt);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset, a directed sequence, then random episodes of marks mixed
    // with other commands, each closed by a flush or a clear.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned done_items;
        int          style;
        int          base;
        int          len;
        int          pick;
        int          r;
        int          c;

        done_items = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Flush on an empty table, then an empty mark. An unknown command
        // must not answer. A mark at the top row with a count of 4096 reaches the
        // highest end row.
        send_beat(CMD_FLUSH, 12'd0, 13'd0);
        send_beat(CMD_MARK, 12'd0, 13'd0);
        send_beat(CMD_UNKNOWN, 12'hFFF, 13'h1FFF);
        send_beat(CMD_MARK, 12'd4095, 13'd4096);
        send_beat(CMD_CLEAR, 12'hFFF, 13'd4096);
        send_beat(CMD_FLUSH, 12'hAAA, 13'h0555);

        // Fill the table with sixteen separate ranges. They are inserted
        // from the top down, so every insert goes at the head.
        for (int k = MAX_RANGES - 1; k >= 0; k--)
            send_beat(CMD_MARK, ROW_W'(k * 200 + 100), 13'd50);

        // The table is full. A separate range below the first one is folded
        // into it, and one above the last is folded into the last.
        send_beat(CMD_MARK, 12'd10, 13'd5);
        send_beat(CMD_MARK, 12'd4000, 13'd96);
        // A range that touches one entry at its start and another at its
        // end, and covers two entries in between.
        send_beat(CMD_MARK, 12'd150, 13'd550);
        send_beat(CMD_FLUSH, 12'd0, 13'd0);

        // In each random episode, marks are drawn around one pattern and
        // mixed with some noise.
        // Dense marks in a narrow window overflow the table. Wide marks cover
        // large spans and merge. Edge marks lean to the row and count limits.
        while (done_items < RANDOM_ITEMS) begin
            style    = $urandom_range(0, 3);
            base     = $urandom_range(0, 3800);
            len      = $urandom_range(4, 30);
            tx_burst = ($urandom_range(0, 4) == 0);
            for (int n = 0; n < len; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    send_beat(CMD_UNKNOWN, ROW_W'($urandom_range(0, 4095)),
                              CNT_W'($urandom_range(0, 4096)));
                end else begin
                    if (pick < 6) begin
                        send_beat(CMD_CLEAR, ROW_W'($urandom_range(0, 4095)),
                                  CNT_W'($urandom_range(0, 4096)));
                    end else if (pick < 10) begin
                        send_beat(CMD_FLUSH, ROW_W'($urandom_range(0, 4095)),
                                  CNT_W'($urandom_range(0, 4096)));
                    end else begin
                        case (style)
                            0: begin
                                r = base + $urandom_range(0, 295);
                                c = $urandom_range(0, 5);
                            end
                            1: begin
                                r = $urandom_range(0, 4095);
                                c = $urandom_range(0, 300);
                            end
                            2: begin
                                r = $urandom_range(0, 4095);
                                case ($urandom_range(0, 3))
                                    0: c = 0;
                                    1: c = 4096;
                                    default: c = $urandom_range(0, 4096);
                                endcase
                            end
                            default: begin
                                case ($urandom_range(0, 2))
                                    0: r = 0;
                                    1: r = 4095;
                                    default: r = $urandom_range(0, 4095);
                                endcase
                                case ($urandom_range(0, 3))
                                    0: c = 0;
                                    1: c = 1;
                                    2: c = 4096;
                                    default: c = $urandom_range(0, 4096);
                                endcase
                            end
                        endcase
                        send_beat(CMD_MARK, ROW_W'(r), CNT_W'(c));
                    end
                    done_items++;
                    if (done_items >= 120)
                        hold_go = 1'b1;
                end
            end
            if ($urandom_range(0, 6) == 0)
                send_beat(CMD_CLEAR, ROW_W'($urandom_range(0, 4095)),
                          CNT_W'($urandom_range(0, 4096)));
            else
                send_beat(CMD_FLUSH, ROW_W'($urandom_range(0, 4095)),
                          CNT_W'($urandom_range(0, 4096)));
            done_items++;
        end
        i_in_valid <= 1'b0;

        // Wait for every expected beat to arrive. Then allow enough cycles
        // for a full mark pass, so that a stray beat after the last flush or
        // clear is still seen.
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("dirty_row_range_merger_core: match");
        else
            $display("dirty_row_range_merger_core: mismatch");
        $finish;
    end

endmodule
